@@ rtl/core/gasp_pkg.sv @@
// Package for the glyph atlas shelf packer: shared constants, status codes,
// controller state type and the placement entry / placer result structs.
// No dependencies.
package gasp_pkg;

    localparam int CODE_COUNT_DEF = 256;

    localparam int SIDE_W  = 13;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 8;
    localparam int CODE_W  = 8;

    localparam logic [SIDE_W-1:0] ATLAS_SIZE_RST = 13'd128;
    localparam logic [SIDE_W-1:0] SIDE_MIN       = 13'd128;
    localparam logic [SIDE_W-1:0] SIDE_MAX       = 13'd4096;

    localparam logic [1:0] STATUS_HIT    = 2'd0;
    localparam logic [1:0] STATUS_PLACED = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } gasp_state_t;

    // stored placement, x in the lowest bits
    typedef struct packed {
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } entry_t;

    typedef struct packed {
        logic               fits;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } place_res_t;

endpackage

@@ rtl/core/glyph_atlas_shelf_packer_top.sv @@
// Glyph atlas shelf packer, top level: controller, placement table and
// output register. Depends on gasp_pkg, gasp_ram and gasp_place.
//
// The placement table RAM is read in the cycle the transaction is accepted,
// and in the lookup state the entry is resolved (hit, reject, or shelf
// placement) and written back together with the cursor update. A request is
// held in the lookup state only while the previous result still sits
// unaccepted in the output register. Valid bits for the table are flip-flops
// cleared by reset, so no clearing pass is needed. Status travels on m_tuser;
// a char_code at or above CODE_COUNT is rejected. atlas_size is saturated to
// 128..4096 and should be written only while no request is in flight.
module glyph_atlas_shelf_packer_top #(
    parameter int CODE_COUNT = gasp_pkg::CODE_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [gasp_pkg::SIDE_W-1:0] cfg_wr_data,    // atlas_size
    // request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,        // char_code, glyph_w, glyph_h
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,        // atlas_x, atlas_y, placed_w, placed_h
    output logic [1:0]                  m_tuser         // status
);
    import gasp_pkg::*;

    localparam int IDX_W = $clog2(CODE_COUNT);
    localparam logic [CODE_W:0] CODE_LIM = (CODE_W+1)'(CODE_COUNT);

    gasp_state_t state_reg, state_next;

    logic [SIDE_W-1:0]  atlas_size_reg;
    logic [SIDE_W-1:0]  side;

    logic [CODE_W-1:0]  code_reg;
    logic [DIM_W-1:0]   w_reg, h_reg;
    logic [CODE_COUNT-1:0] valid_reg;

    logic               s_fire, finish;
    logic [IDX_W-1:0]   idx;
    entry_t             rd_entry, wr_entry;
    logic               tbl_wr, pack_en;
    place_res_t         place_res;
    logic               atlas_full;

    logic               m_valid_reg;
    logic [1:0]         status_res, m_status_reg;
    entry_t             out_res, m_out_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_size_reg <= ATLAS_SIZE_RST;
        end else if (cfg_wr_en) begin
            atlas_size_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        priority if (atlas_size_reg < SIDE_MIN) begin
            side = SIDE_MIN;
        end else if (atlas_size_reg > SIDE_MAX) begin
            side = SIDE_MAX;
        end else begin
            side = atlas_size_reg;
        end
    end

    // controller
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_LOOKUP: finish   = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                finish   = 1'b0;
            end
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            code_reg <= s_tdata[7:0];
            w_reg    <= s_tdata[15:8];
            h_reg    <= s_tdata[23:16];
        end
    end

    // placement table
    assign idx = code_reg[IDX_W-1:0];

    gasp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CODE_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (idx),
        .wr_data (wr_entry),
        .rd_en   (s_fire),
        .rd_addr (s_tdata[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    gasp_place u_place (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .side       (side),
        .glyph_w    (w_reg),
        .glyph_h    (h_reg),
        .pack_en    (pack_en),
        .res        (place_res),
        .atlas_full (atlas_full)
    );

    // resolve the request
    always_comb begin
        tbl_wr     = 1'b0;
        pack_en    = 1'b0;
        status_res = STATUS_REJECT;
        out_res    = '0;
        wr_entry.x = '0;
        wr_entry.y = '0;
        wr_entry.w = w_reg;
        wr_entry.h = h_reg;
        priority if ({1'b0, code_reg} >= CODE_LIM) begin
            status_res = STATUS_REJECT;
        end else if (valid_reg[idx]) begin
            status_res = STATUS_HIT;
            out_res    = rd_entry;
        end else if (atlas_full) begin
            status_res = STATUS_REJECT;
        end else if (w_reg == '0 || h_reg == '0) begin
            // empty glyph: cached at the origin, cursor untouched
            status_res = STATUS_PLACED;
            tbl_wr     = finish;
            out_res    = wr_entry;
        end else begin
            pack_en = finish;
            if (place_res.fits) begin
                wr_entry.x = place_res.x;
                wr_entry.y = place_res.y;
                status_res = STATUS_PLACED;
                tbl_wr     = finish;
                out_res    = wr_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (tbl_wr) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_status_reg <= status_res;
            m_out_reg    <= out_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_out_reg;

endmodule

@@ rtl/core/gasp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gasp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/gasp_place.sv @@
// Shelf placer: holds the shelf cursor, shelf height and sticky full flag,
// and works out where a nonempty glyph lands. Depends on gasp_pkg.
module gasp_place (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [gasp_pkg::SIDE_W-1:0] side,
    input  logic [gasp_pkg::DIM_W-1:0]  glyph_w,
    input  logic [gasp_pkg::DIM_W-1:0]  glyph_h,
    input  logic                        pack_en,
    output gasp_pkg::place_res_t        res,
    output logic                        atlas_full
);
    import gasp_pkg::*;

    logic [SIDE_W-1:0] shelf_x_reg, shelf_x_next;
    logic [SIDE_W-1:0] shelf_y_reg, shelf_y_next;
    logic [DIM_W-1:0]  shelf_h_reg, shelf_h_next;
    logic              full_reg, full_next;

    logic [SIDE_W:0]   x_end, y_end;
    logic              new_shelf;
    logic [SIDE_W-1:0] x_base, y_base;
    logic [DIM_W-1:0]  h_base;

    always_comb begin
        x_end     = {1'b0, shelf_x_reg} + {{(SIDE_W+1-DIM_W){1'b0}}, glyph_w} + 14'd1;
        new_shelf = x_end > {1'b0, side};
        // a new shelf is kept even when the glyph then overflows the height
        x_base = new_shelf ? '0 : shelf_x_reg;
        y_base = new_shelf ? shelf_y_reg + {{(SIDE_W-DIM_W){1'b0}}, shelf_h_reg} + 13'd1
                           : shelf_y_reg;
        h_base = new_shelf ? '0 : shelf_h_reg;
        y_end  = {1'b0, y_base} + {{(SIDE_W+1-DIM_W){1'b0}}, glyph_h} + 14'd1;

        res.fits = y_end <= {1'b0, side};
        res.x    = x_base[COORD_W-1:0];
        res.y    = y_base[COORD_W-1:0];

        shelf_y_next = y_base;
        if (res.fits) begin
            shelf_x_next = x_base + {{(SIDE_W-DIM_W){1'b0}}, glyph_w} + 13'd1;
            shelf_h_next = (glyph_h > h_base) ? glyph_h : h_base;
            full_next    = full_reg;
        end else begin
            shelf_x_next = x_base;
            shelf_h_next = h_base;
            full_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shelf_x_reg <= '0;
            shelf_y_reg <= '0;
            shelf_h_reg <= '0;
            full_reg    <= 1'b0;
        end else if (pack_en) begin
            shelf_x_reg <= shelf_x_next;
            shelf_y_reg <= shelf_y_next;
            shelf_h_reg <= shelf_h_next;
            full_reg    <= full_next;
        end
    end

    assign atlas_full = full_reg;

endmodule

@@ test/tb_glyph_atlas_shelf_packer_top.sv @@
// Self-checking testbench for glyph_atlas_shelf_packer_top: directed rows, then
// random glyph requests over several atlas sizes, checked against a shelf-packing predictor.
// Depends on gasp_pkg and the packer RTL.
`timescale 1ns / 1ps

module tb_glyph_atlas_shelf_packer_top;
    import gasp_pkg::*;

    localparam int CODE_COUNT   = gasp_pkg::CODE_COUNT_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int RX_HOLD      = 400;
    localparam int RANDOM_ITEMS = 550;

    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } glyph_result_t;

    typedef enum logic {
        ROW_GLYPH,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [SIDE_W-1:0]  size;
        logic [CODE_W-1:0]  code;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic               typed;
        glyph_result_t      res;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [SIDE_W-1:0]   cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;       // char_code, glyph_w, glyph_h
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;       // atlas_x, atlas_y, placed_w, placed_h
    logic [1:0]          m_tuser;       // status

    // predictor state
    logic                slot_valid [CODE_COUNT];
    entry_t              slot_store [CODE_COUNT];
    int                  cur_shelf_x;
    int                  cur_shelf_y;
    int                  cur_shelf_ht;
    bit                  atlas_is_full;
    logic [SIDE_W-1:0]   atlas_size_q;

    glyph_result_t       pending_results [$];
    plan_row_t           glyph_plan [$];

    int                  src_idle_pct = 0;
    int                  rx_idle_pct = 0;
    bit                  hold_req = 1'b0;
    int                  fault_count = 0;
    int                  stall_cycles = 0;

    glyph_atlas_shelf_packer_top #(
        .CODE_COUNT(CODE_COUNT)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shelf packer prediction; updates the cache and cursor as the block would.
    function automatic glyph_result_t place_glyph(input logic [CODE_W-1:0] code,
                                                  input logic [DIM_W-1:0] w,
                                                  input logic [DIM_W-1:0] h);
        glyph_result_t r;
        int            side;
        int            px;
        int            py;
        r = '0;
        r.status = STATUS_REJECT;
        px = 0;
        py = 0;
        if (atlas_size_q < SIDE_MIN)
            side = int'(SIDE_MIN);
        else if (atlas_size_q > SIDE_MAX)
            side = int'(SIDE_MAX);
        else
            side = int'(atlas_size_q);
        if (int'(code) >= CODE_COUNT)
            return r;
        if (slot_valid[code]) begin
            r.status = STATUS_HIT;
            r.x = slot_store[code].x;
            r.y = slot_store[code].y;
            r.w = slot_store[code].w;
            r.h = slot_store[code].h;
            return r;
        end
        if (atlas_is_full)
            return r;
        if (w != 0 && h != 0) begin
            // new shelf is kept even when the height then overflows
            if (cur_shelf_x + int'(w) + 1 > side) begin
                cur_shelf_x = 0;
                cur_shelf_y = cur_shelf_y + cur_shelf_ht + 1;
                cur_shelf_ht = 0;
            end
            if (cur_shelf_y + int'(h) + 1 > side) begin
                atlas_is_full = 1'b1;
                return r;
            end
            px = cur_shelf_x;
            py = cur_shelf_y;
            if (int'(h) > cur_shelf_ht)
                cur_shelf_ht = int'(h);
            cur_shelf_x = cur_shelf_x + int'(w) + 1;
        end
        slot_valid[code] = 1'b1;
        slot_store[code].x = COORD_W'(px);
        slot_store[code].y = COORD_W'(py);
        slot_store[code].w = w;
        slot_store[code].h = h;
        r.status = STATUS_PLACED;
        r.x = COORD_W'(px);
        r.y = COORD_W'(py);
        r.w = w;
        r.h = h;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input bit bulky);
        int r;
        r = $urandom_range(0, 99);
        if (bulky && r < 85)
            return DIM_W'($urandom_range(64, 255));
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 70)
            return DIM_W'($urandom_range(1, 32));
        return DIM_W'($urandom_range(1, 255));
    endfunction

    task automatic plan_row(input row_kind_t kind, input int a, input int b, input int c,
                            input bit typed, input logic [1:0] st,
                            input int ex, input int ey, input int ew, input int eh);
        plan_row_t row;
        row = '0;
        row.kind = kind;
        if (kind == ROW_SIZE) begin
            row.size = SIDE_W'(a);
        end else begin
            row.code = CODE_W'(a);
            row.w = DIM_W'(b);
            row.h = DIM_W'(c);
        end
        row.typed = typed;
        row.res.status = st;
        row.res.x = COORD_W'(ex);
        row.res.y = COORD_W'(ey);
        row.res.w = DIM_W'(ew);
        row.res.h = DIM_W'(eh);
        glyph_plan.push_back(row);
    endtask

    task automatic send_glyph(input logic [CODE_W-1:0] code, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h, input bit typed,
                              input glyph_result_t typed_res);
        glyph_result_t r;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h, w, code};
        do @(posedge aclk); while (!s_tready);
        r = place_glyph(code, w, h);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // drains all pending results first, so nothing is in flight when it writes
    task automatic write_atlas_size(input logic [SIDE_W-1:0] v);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        atlas_size_q = v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        glyph_result_t want;
        glyph_result_t got;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = {m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[31:24], m_tdata[39:32]};
            if (pending_results.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result: st=%0d x=%0d y=%0d w=%0d h=%0d",
                             got.status, got.x, got.y, got.w, got.h);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
                    got.w !== want.w || got.h !== want.h) begin
                    if (fault_count < 10) begin
                        $display("mismatch: exp st=%0d x=%0d y=%0d w=%0d h=%0d",
                                 want.status, want.x, want.y, want.w, want.h);
                        $display("          got st=%0d x=%0d y=%0d w=%0d h=%0d",
                                 got.status, got.x, got.y, got.w, got.h);
                    end
                    fault_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** glyph_atlas_shelf_packer_top: FAILED **");
            $finish;
        end
    end

    initial begin
        plan_row_t          row;
        logic [CODE_W-1:0]  code;
        int                 code_max;
        int                 ph;
        int                 n;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        for (n = 0; n < CODE_COUNT; n++) begin
            slot_valid[n] = 1'b0;
            slot_store[n] = '0;
        end
        cur_shelf_x   = 0;
        cur_shelf_y   = 0;
        cur_shelf_ht  = 0;
        atlas_is_full = 1'b0;
        atlas_size_q  = ATLAS_SIZE_RST;

        // directed rows
        plan_row(ROW_GLYPH, 8'h41, 10, 12, 1, STATUS_PLACED, 0, 0, 10, 12);
        plan_row(ROW_GLYPH, 8'h41, 255, 255, 1, STATUS_HIT, 0, 0, 10, 12);
        plan_row(ROW_SIZE, 0, 0, 0, 0, STATUS_HIT, 0, 0, 0, 0);       // saturates to 128
        plan_row(ROW_GLYPH, 8'h00, 0, 0, 1, STATUS_PLACED, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'h01, 0, 255, 1, STATUS_PLACED, 0, 0, 0, 255);
        plan_row(ROW_GLYPH, 8'h02, 255, 0, 1, STATUS_PLACED, 0, 0, 255, 0);
        plan_row(ROW_GLYPH, 8'h00, 7, 7, 1, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'h03, 116, 5, 0, STATUS_HIT, 0, 0, 0, 0); // fills the shelf exactly
        plan_row(ROW_GLYPH, 8'h04, 1, 1, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'h05, 255, 20, 0, STATUS_HIT, 0, 0, 0, 0); // wider than the atlas
        plan_row(ROW_GLYPH, 8'h06, 1, 1, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_SIZE, 8191, 0, 0, 0, STATUS_HIT, 0, 0, 0, 0);    // saturates to 4096
        plan_row(ROW_GLYPH, 8'h07, 200, 100, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'hFF, 255, 255, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'h80, 128, 1, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'h07, 1, 1, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_SIZE, 4096, 0, 0, 0, STATUS_HIT, 0, 0, 0, 0);
        plan_row(ROW_GLYPH, 8'hAA, 255, 255, 0, STATUS_HIT, 0, 0, 0, 0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 34;
        rx_idle_pct  = 81;
        foreach (glyph_plan[i]) begin
            row = glyph_plan[i];
            case (row.kind)
                ROW_SIZE: begin
                    write_atlas_size(row.size);
                end
                default: begin
                    send_glyph(row.code, row.w, row.h, row.typed, row.res);
                end
            endcase
        end

        // random phases; the last one shrinks the atlas so that it fills up
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_atlas_size(13'd4095);
                    code_max = 127;
                    hold_req = 1'b1;
                end
                1: begin
                    src_idle_pct = 81;
                    rx_idle_pct  = 34;
                    write_atlas_size(SIDE_W'($urandom_range(3500, 4095)));
                    code_max = 191;
                end
                default: begin
                    src_idle_pct = 0;
                    rx_idle_pct  = 0;
                    drain_results();
                    write_atlas_size(SIDE_W'(cur_shelf_y + $urandom_range(150, 400)));
                    code_max = 255;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS; n++) begin
                code = CODE_W'($urandom_range(0, code_max));
                send_glyph(code, pick_dim(ph == 2), pick_dim(ph == 2), 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fault_count == 0)
            $display("** glyph_atlas_shelf_packer_top: PASSED **");
        else
            $display("** glyph_atlas_shelf_packer_top: FAILED **");
        $finish;
    end

endmodule
